FILE: rtl/pcm_pkg.sv
`default_nettype none
package pcm_pkg;

   // Command codes of an input item
   localparam logic CMD_CAPTURE  = 1'b0;
   localparam logic CMD_OVERFLOW = 1'b1;

   // Measurement phases
   localparam logic [1:0] PHASE_RISE = 2'd0;
   localparam logic [1:0] PHASE_FALL = 2'd1;
   localparam logic [1:0] PHASE_NEXT = 2'd2;

   localparam int unsigned STAMP_W      = 32;
   localparam int unsigned DIV_STEPS    = 32;
   localparam logic [15:0] RELOAD_RESET = 16'hFFFF;
   localparam logic [31:0] DUTY_SCALE   = 32'd1000;

   typedef struct packed {
      logic        cmd;
      logic [15:0] capture_value;
   } req_type;

   typedef struct packed {
      logic [15:0] pulse_width;
      logic [15:0] period_length;
      logic [15:0] duty_permille;
      logic        new_measurement;
   } rsp_type;

   // Queue entry, classified by the front end
   typedef struct packed {
      logic        is_tick;
      logic [15:0] capture_value;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

FILE: rtl/pcm_front.sv
`default_nettype none
module pcm_front #(
   parameter int unsigned DEPTH = 2
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  pcm_pkg::req_type    req_data,
   output logic                entry_valid,
   input  wire                 entry_pop,
   output pcm_pkg::entry_type  entry_data
);
   import pcm_pkg::*;

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type         queue_ff [DEPTH];
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;
   entry_type         new_entry;

   assign req_ready   = (count_ff != CNT_W'(DEPTH));
   assign entry_valid = (count_ff != '0);
   assign entry_data  = queue_ff[rd_ptr_ff];
   assign push        = req_valid && req_ready;
   assign pop         = entry_pop && entry_valid;

   // classify: overflow tick or edge capture
   always_comb begin
      new_entry.is_tick       = (req_data.cmd == CMD_OVERFLOW);
      new_entry.capture_value = req_data.capture_value;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
   a_push_only: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance on push");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with pointers apart");
`endif

endmodule
`default_nettype wire

FILE: rtl/pcm_divider.sv
`default_nettype none
module pcm_divider (
   input  wire                   clock,
   input  wire                   reset,
   input  pcm_pkg::div_req_type  div_req,
   output pcm_pkg::div_rsp_type  div_rsp
);
   import pcm_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIV_STEPS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic [STAMP_W-1:0]  rem_ff, rem_in;
   logic [STAMP_W-1:0]  quo_ff, quo_in;
   logic [STAMP_W-1:0]  divisor_ff, divisor_in;
   logic [STAMP_W:0]    shifted;
   logic [STAMP_W:0]    diff;
   logic                fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign shifted = {rem_ff, quo_ff[STAMP_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};
   assign fits    = (shifted >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start && !busy_ff) begin
         busy_in    = 1'b1;
         step_in    = CNT_W'(DIV_STEPS - 1);
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[STAMP_W-1:0] : shifted[STAMP_W-1:0];
         quo_in  = {quo_ff[STAMP_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

`ifndef NO_ASSERTIONS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a preceding run");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff && step_ff != '0 |=> busy_ff)
      else $error("divider stopped early");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff && divisor_ff != '0 |-> rem_ff < divisor_ff)
      else $error("partial remainder not below divisor");
`endif

endmodule
`default_nettype wire

FILE: rtl/pcm_back.sv
`default_nettype none
module pcm_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire [15:0]            reload_value,
   input  wire                   entry_valid,
   output logic                  entry_pop,
   input  pcm_pkg::entry_type    entry_data,
   output pcm_pkg::div_req_type  div_req,
   input  pcm_pkg::div_rsp_type  div_rsp,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output pcm_pkg::rsp_type      rsp_data
);
   import pcm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_STAMP = 6'b000100,
      ST_DIVST = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [1:0]          phase_ff, phase_in;
   logic [STAMP_W-1:0]  rising_ff, rising_in;
   logic [STAMP_W-1:0]  high_ff, high_in;
   logic [STAMP_W-1:0]  period_ff, period_in;
   logic [15:0]         duty_ff, duty_in;
   logic [STAMP_W-1:0]  ovf_ff, ovf_in;
   logic [15:0]         cap_ff, cap_in;
   logic [STAMP_W-1:0]  prod_ff, prod_in;
   logic [STAMP_W-1:0]  scaled_ff, scaled_in;
   logic                fresh_ff, fresh_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [STAMP_W-1:0]  span;
   logic [STAMP_W-1:0]  stamp;
   logic [STAMP_W-1:0]  delta;

   assign span  = {16'b0, reload_value} + 32'd1;
   assign stamp = {16'b0, cap_ff} + prod_ff;
   assign delta = stamp - rising_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rising_in    = rising_ff;
      high_in      = high_ff;
      period_in    = period_ff;
      duty_in      = duty_ff;
      ovf_in       = ovf_ff;
      cap_in       = cap_ff;
      prod_in      = ovf_ff * span;
      scaled_in    = high_ff * DUTY_SCALE;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      entry_pop    = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = scaled_ff;
      div_req.divisor  = period_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (entry_valid) begin
               entry_pop = 1'b1;
               fresh_in  = 1'b0;
               cap_in    = entry_data.capture_value;
               if (entry_data.is_tick) begin
                  ovf_in   = ovf_ff + 1'b1;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            // prod_ff now holds overflow_count * (reload + 1)
            state_in = ST_STAMP;
         end
         ST_STAMP: begin
            state_in = ST_OUT;
            unique case (phase_ff)
               PHASE_FALL: begin
                  high_in  = delta;
                  phase_in = PHASE_NEXT;
               end
               PHASE_NEXT: begin
                  period_in = delta;
                  phase_in  = PHASE_RISE;
                  ovf_in    = '0;
                  if (delta != '0) begin
                     state_in = ST_DIVST;
                  end
               end
               default: begin
                  rising_in = stamp;
                  phase_in  = PHASE_FALL;
               end
            endcase
         end
         ST_DIVST: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               duty_in  = div_rsp.quotient[15:0];
               fresh_in = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_in.pulse_width     = high_ff[15:0];
               rsp_in.period_length   = period_ff[15:0];
               rsp_in.duty_permille   = duty_ff;
               rsp_in.new_measurement = fresh_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PHASE_RISE;
         rising_ff    <= '0;
         high_ff      <= '0;
         period_ff    <= '0;
         duty_ff      <= '0;
         ovf_ff       <= '0;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rising_ff    <= rising_in;
         high_ff      <= high_in;
         period_ff    <= period_in;
         duty_ff      <= duty_in;
         ovf_ff       <= ovf_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff    <= cap_in;
      prod_ff   <= prod_in;
      scaled_ff <= scaled_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("back-end state not one-hot");
   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("unused phase code reached");
   a_div_window: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider result outside the wait state");
   a_fresh_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in && !rsp_valid_ff && rsp_in.new_measurement |-> period_ff != '0)
      else $error("new measurement flagged with zero period");
`endif

endmodule
`default_nettype wire

FILE: rtl/pwm_input_capture_meter.sv
`default_nettype none
// Channel   Ports                                Payload
// req       req_valid, req_ready, req_data       cmd, capture_value
// rsp       rsp_valid, rsp_ready, rsp_data       pulse_width, period_length,
//                                                duty_permille, new_measurement
// csr       csr_valid, csr_ready, csr_data       reload_value (16 bits)
//
// Back end: an overflow tick goes straight to the output state; an edge capture
// passes through the multiply and stamp states, and the capture that closes a
// nonzero period also runs the 32-step restoring divider that forms the duty in
// permille.
// Reset: synchronous, active high; clears phase, stamps, counts and the queue,
// and sets reload_value to 65535.
// Stalls: the input queue keeps taking transfers while a result waits in the
// output register; req_ready drops only when the queue is full.
module pwm_input_capture_meter #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  pcm_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output pcm_pkg::rsp_type  rsp_data,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire [15:0]        csr_data
);
   import pcm_pkg::*;

   logic [15:0]  reload_ff, reload_in;
   logic         entry_valid;
   logic         entry_pop;
   entry_type    entry_data;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   // Config transfers always taken, no check: the user must make them arrive only while idle.
   assign csr_ready = 1'b1;
   assign reload_in = (csr_valid && csr_ready) ? csr_data : reload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff <= RELOAD_RESET;
      end else begin
         reload_ff <= reload_in;
      end
   end

   // Front end: accept and classify items into a short queue.
   pcm_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .entry_valid (entry_valid),
      .entry_pop   (entry_pop),
      .entry_data  (entry_data)
   );

   // Back end: extend the stamp, advance the phase, hold the result.
   pcm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .reload_value (reload_ff),
      .entry_valid  (entry_valid),
      .entry_pop    (entry_pop),
      .entry_data   (entry_data),
      .div_req      (div_req),
      .div_rsp      (div_rsp),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   // Iterative divider for the duty cycle.
   pcm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule
`default_nettype wire
